// ===== rtl/gtd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Goertzel tone detector package
// Shared widths, codes, configuration/result types and defaults for the detector.
// ----------------------------------------------------------------------------
package gtd_pkg;

  // Fixed field widths.
  localparam int CMD_W      = 2;
  localparam int SMP_PORT_W = 10;
  localparam int CNT_W      = 11;
  localparam int COEF_W     = 16;
  localparam int CENTER_W   = 10;
  localparam int MAG_W      = 63;
  localparam int ENERGY_W   = 32;
  localparam int PUR_W      = 16;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Arithmetic.
  localparam int FRAC_BITS  = 14;
  localparam int UNIT_W     = 31;
  localparam int PAB_W      = 2 * UNIT_W;
  localparam int XP_W       = COEF_W + UNIT_W;
  localparam int T_W        = 78;
  localparam int D_W        = CNT_W + ENERGY_W;
  localparam int REM_W      = D_W + 1;
  localparam int Q_W        = PUR_W + 1;
  localparam int DIV_STEPS  = Q_W;
  localparam int DIV_CNT_W  = 5;

  // Block-level defaults.
  localparam int MAX_BLOCK_DEF   = 1024;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int STATE_BITS_DEF  = 48;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CNT_MAX         = (1 << CNT_W) - 1;

  localparam logic [CENTER_W-1:0] CENTER_RST = CENTER_W'(128);
  localparam logic [CNT_W-1:0]    LIMIT_RST  = CNT_W'(1024);

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_DETECT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } gtd_op_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_SAT    = 2'd3
  } gtd_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEFFICIENT = 2'd0,
    CFG_ADC_CENTER  = 2'd1,
    CFG_BLOCK_LIMIT = 2'd2
  } gtd_cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RND,
    S_SUB,
    S_ADD,
    S_UNIT,
    S_SQ,
    S_CX,
    S_SUM,
    S_ACC,
    S_RNDM,
    S_CHK,
    S_DIV
  } gtd_state_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic [CENTER_W-1:0]      adc_center;
    logic [CNT_W-1:0]         block_limit;
  } gtd_cfg_t;

  typedef struct packed {
    gtd_status_t         status;
    logic [CNT_W-1:0]    sample_count;
    logic [MAG_W-1:0]    magnitude_squared;
    logic [ENERGY_W-1:0] energy;
    logic [PUR_W-1:0]    purity;
  } gtd_result_t;

endpackage

// ===== rtl/gtd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Goertzel request queue
// Small FIFO between the request front end and the back end.
// ----------------------------------------------------------------------------
module gtd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  assign full  = (fill_r == FILL_W'(DEPTH));
  assign empty = (fill_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/gtd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Goertzel front end
// Holds the configuration registers, decodes requests and removes the ADC
// offset before queueing them for the back end.
// ----------------------------------------------------------------------------
module gtd_front
  import gtd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [SMP_PORT_W-1:0] in_sample,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  q_full,
  output logic                  q_push,
  output logic [OP_W+((SAMPLE_BITS < SMP_PORT_W) ? SAMPLE_BITS : SMP_PORT_W):0] q_wdata,
  output gtd_cfg_t              cfg
);

  localparam int SMP_W = (SAMPLE_BITS < SMP_PORT_W) ? SAMPLE_BITS : SMP_PORT_W;
  localparam int X_W   = SMP_W + 1;

  logic signed [COEF_W-1:0] coef_r, coef_nxt;
  logic [CENTER_W-1:0]      center_r, center_nxt;
  logic [CNT_W-1:0]         limit_r, limit_nxt;
  gtd_op_t                  op;
  logic signed [X_W-1:0]    x;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign q_push    = in_valid && !q_full;

  always_comb begin
    coef_nxt   = coef_r;
    center_nxt = center_r;
    limit_nxt  = limit_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COEFFICIENT: coef_nxt   = cfg_data;
        CFG_ADC_CENTER:  center_nxt = cfg_data[CENTER_W-1:0];
        CFG_BLOCK_LIMIT: limit_nxt  = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r   <= '0;
      center_r <= CENTER_RST;
      limit_r  <= LIMIT_RST;
    end else begin
      coef_r   <= coef_nxt;
      center_r <= center_nxt;
      limit_r  <= limit_nxt;
    end
  end

  assign cfg.coefficient = coef_r;
  assign cfg.adc_center  = center_r;
  assign cfg.block_limit = limit_r;

  // Every command value maps onto one of the four operation codes.
  assign op = gtd_op_t'(in_command);

  // Only the low sample bits of both the sample and the center take part.
  assign x = $signed({1'b0, in_sample[SMP_W-1:0]}) - $signed({1'b0, center_r[SMP_W-1:0]});
  assign q_wdata = {op, x};

endmodule

// ===== rtl/gtd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Goertzel back end
// Runs the saturating recursion, the magnitude and purity computation and
// owns the block state and the result register.
// ----------------------------------------------------------------------------
module gtd_back
  import gtd_pkg::*;
#(
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  gtd_cfg_t    cfg,
  input  logic        q_empty,
  input  logic [OP_W+((SAMPLE_BITS < SMP_PORT_W) ? SAMPLE_BITS : SMP_PORT_W):0] q_rdata,
  output logic        q_pop,
  input  logic        out_stall,
  output logic        out_valid,
  output gtd_result_t result
);

  localparam int SMP_W = (SAMPLE_BITS < SMP_PORT_W) ? SAMPLE_BITS : SMP_PORT_W;
  localparam int X_W   = SMP_W + 1;
  localparam int SQ_W  = 2 * X_W;
  localparam int SW    = STATE_BITS;
  localparam int PW    = SW + COEF_W;
  localparam int MAX_CLIP_I = (MAX_BLOCK > CNT_MAX) ? CNT_MAX : MAX_BLOCK;
  localparam logic [CNT_W-1:0] MAX_CLIP = CNT_W'(MAX_CLIP_I);
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [UNIT_W-1:0] UNIT_MAX = '1;

  // Rounds a state to sample units (ties away from zero), clipped to 31 bits.
  function automatic logic [UNIT_W-1:0] unit_mag(input logic signed [SW-1:0] v);
    logic signed [63:0] w;
    logic [63:0]        a;
    logic [63:0]        u;
    w = 64'(v);
    a = w[63] ? (64'd0 - w) : w;
    u = ((a >> 1) + 64'd4096) >> (FRAC_BITS - 1);
    return (u > 64'(UNIT_MAX)) ? UNIT_MAX : u[UNIT_W-1:0];
  endfunction

  gtd_state_t state_r, state_nxt;

  // Block state.
  logic signed [SW-1:0] latest_r, prev_r;
  logic [ENERGY_W-1:0]  energy_r;
  logic [CNT_W-1:0]     count_r;

  // Recursion pipeline.
  logic signed [X_W-1:0] x_r;
  logic signed [PW-1:0]  prod_r;
  logic [SQ_W-1:0]       sq_r;
  logic signed [SW-1:0]  s_r;
  logic                  sat_r;
  logic [ENERGY_W-1:0]   en_sum_r;

  // Detect pipeline.
  logic [UNIT_W-1:0] am_r, bm_r;
  logic              neg_r;
  logic [D_W-1:0]    d_r;
  logic [PAB_W-1:0]  sqa_r, sqb_r, pab_r;
  logic [T_W-1:0]    t_r, xsum_r, acc_r;
  logic [XP_W-1:0]   xlo_r, xhi_r;
  logic [MAG_W-1:0]  mag_r;
  logic              msat_r;
  logic [REM_W-1:0]  rem_r;
  logic [Q_W-1:0]    nbits_r, q_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic        out_valid_r;
  gtd_result_t res_r, res_nxt;

  // Control.
  logic    out_free, start, blk_full, res_load, blk_clear, blk_commit;
  logic [CNT_W-1:0] lim_eff;
  gtd_op_t hop;
  logic signed [X_W-1:0] hx;

  // Datapath intermediates.
  logic signed [PW-1:0]  prod_nxt;
  logic signed [SQ_W-1:0] sq_full;
  logic [PW-1:0]         rsum;
  logic signed [SW+1:0]  rnd;
  logic                  rnd_sat;
  logic signed [SW-1:0]  s_rnd;
  logic [ENERGY_W:0]     esum;
  logic [ENERGY_W-1:0]   en_sum_nxt;
  logic [SW:0]           diff, xs, asum;
  logic                  sub_ovf, add_ovf;
  logic signed [SW-1:0]  s_sub, s_add;
  logic [COEF_W-1:0]     c_abs;
  logic [PAB_W:0]        s_sq;
  logic [T_W-1:0]        t_add;
  logic [T_W:0]          t_diff;
  logic [T_W-1:0]        acc_nxt, rm_sum;
  logic [63:0]           rq;
  logic                  d_zero, mag_big, div_last;
  logic [T_W-1:0]        n_init;
  logic [REM_W:0]        trial, trial_sub;
  logic                  ge;
  logic [Q_W-1:0]        q_fin;

  assign hop = gtd_op_t'(q_rdata[OP_W+X_W-1:X_W]);
  assign hx  = $signed(q_rdata[X_W-1:0]);

  assign lim_eff  = (cfg.block_limit > MAX_CLIP) ? MAX_CLIP : cfg.block_limit;
  assign blk_full = (count_r >= lim_eff);
  assign out_free = !out_valid_r || !out_stall;
  assign start    = !q_empty && out_free;

  // ---------------- recursion arithmetic ----------------
  assign prod_nxt = $signed(cfg.coefficient) * latest_r;
  assign sq_full  = hx * hx;

  always_comb begin
    rsum = prod_r + PW'(prod_r[PW-1] ? 14'd8191 : 14'd8192);
    rnd  = $signed(rsum[PW-1:FRAC_BITS]);
    rnd_sat = !((rnd[SW+1] == rnd[SW]) && (rnd[SW] == rnd[SW-1]));
    s_rnd = rnd_sat ? (rnd[SW+1] ? SMIN : SMAX) : rnd[SW-1:0];

    esum = {1'b0, energy_r} + (ENERGY_W+1)'(sq_r);
    en_sum_nxt = esum[ENERGY_W] ? '1 : esum[ENERGY_W-1:0];

    diff    = {s_r[SW-1], s_r} - {prev_r[SW-1], prev_r};
    sub_ovf = diff[SW] ^ diff[SW-1];
    s_sub   = sub_ovf ? (diff[SW] ? SMIN : SMAX) : diff[SW-1:0];

    xs      = (SW+1)'(x_r) <<< FRAC_BITS;
    asum    = {s_r[SW-1], s_r} + xs;
    add_ovf = asum[SW] ^ asum[SW-1];
    s_add   = add_ovf ? (asum[SW] ? SMIN : SMAX) : asum[SW-1:0];
  end

  // ---------------- detect arithmetic ----------------
  always_comb begin
    c_abs  = cfg.coefficient[COEF_W-1] ? (COEF_W'(0) - cfg.coefficient) : cfg.coefficient;
    s_sq   = (PAB_W+1)'(sqa_r) + (PAB_W+1)'(sqb_r);
    t_add  = t_r + xsum_r;
    t_diff = {1'b0, t_r} - {1'b0, xsum_r};
    // A negative cross term adds; otherwise subtract and floor at zero.
    acc_nxt = neg_r ? t_add : (t_diff[T_W] ? '0 : t_diff[T_W-1:0]);
    rm_sum  = acc_r + T_W'(8192);
    rq      = rm_sum[T_W-1:FRAC_BITS];

    d_zero  = (d_r == '0);
    mag_big = (mag_r >= MAG_W'({d_r, 1'b0}));
    n_init  = {mag_r, 15'd0} + T_W'(d_r >> 1);

    trial     = {rem_r, nbits_r[Q_W-1]};
    ge        = (trial >= (REM_W+1)'(d_r));
    trial_sub = trial - (REM_W+1)'(d_r);
    div_last  = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
    q_fin     = {q_r[Q_W-2:0], ge};
  end

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (hop == OP_ADD && !blk_full) begin
            state_nxt = S_RND;
          end else if (hop == OP_DETECT) begin
            state_nxt = S_UNIT;
          end
        end
      end
      S_RND:  state_nxt = S_SUB;
      S_SUB:  state_nxt = S_ADD;
      S_ADD:  state_nxt = S_IDLE;
      S_UNIT: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_CX;
      S_CX:   state_nxt = S_SUM;
      S_SUM:  state_nxt = S_ACC;
      S_ACC:  state_nxt = S_RNDM;
      S_RNDM: state_nxt = S_CHK;
      S_CHK:  state_nxt = (d_zero || mag_big) ? S_IDLE : S_DIV;
      S_DIV:  state_nxt = div_last ? S_IDLE : S_DIV;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    q_pop      = 1'b0;
    res_load   = 1'b0;
    blk_clear  = 1'b0;
    blk_commit = 1'b0;
    res_nxt.status            = STAT_OK;
    res_nxt.sample_count      = count_r;
    res_nxt.magnitude_squared = '0;
    res_nxt.energy            = energy_r;
    res_nxt.purity            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          q_pop = 1'b1;
          unique case (hop)
            OP_ADD: begin
              if (blk_full) begin
                res_load       = 1'b1;
                res_nxt.status = STAT_REJECT;
              end
            end
            OP_DETECT: ;
            OP_CLEAR: begin
              res_load  = 1'b1;
              blk_clear = 1'b1;
            end
            OP_NOP: res_load = 1'b1;
          endcase
        end
      end
      S_ADD: begin
        res_load       = 1'b1;
        blk_commit     = 1'b1;
        res_nxt.energy = en_sum_r;
        res_nxt.status = (sat_r || add_ovf) ? STAT_SAT : STAT_OK;
      end
      S_CHK: begin
        res_nxt.magnitude_squared = mag_r;
        if (d_zero) begin
          res_load       = 1'b1;
          blk_clear      = 1'b1;
          res_nxt.status = STAT_EMPTY;
        end else if (mag_big) begin
          res_load       = 1'b1;
          blk_clear      = 1'b1;
          res_nxt.status = STAT_SAT;
          res_nxt.purity = '1;
        end
      end
      S_DIV: begin
        res_nxt.magnitude_squared = mag_r;
        if (div_last) begin
          res_load       = 1'b1;
          blk_clear      = 1'b1;
          res_nxt.purity = q_fin[Q_W-1] ? '1 : q_fin[PUR_W-1:0];
          res_nxt.status = (q_fin[Q_W-1] || msat_r) ? STAT_SAT : STAT_OK;
        end
      end
      default: ;
    endcase
  end

  // ---------------- control and block state ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      latest_r    <= '0;
      prev_r      <= '0;
      energy_r    <= '0;
      count_r     <= '0;
      div_cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (blk_clear) begin
        latest_r <= '0;
        prev_r   <= '0;
        energy_r <= '0;
        count_r  <= '0;
      end else if (blk_commit) begin
        prev_r   <= latest_r;
        latest_r <= s_add;
        energy_r <= en_sum_r;
        count_r  <= count_r + CNT_W'(1);
      end
      if (state_r == S_DIV) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end else begin
        div_cnt_r <= '0;
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res_nxt;
    end
    unique case (state_r)
      S_IDLE: begin
        prod_r <= prod_nxt;
        sq_r   <= sq_full[SQ_W-1:0];
        x_r    <= hx;
      end
      S_RND: begin
        s_r      <= s_rnd;
        sat_r    <= rnd_sat;
        en_sum_r <= en_sum_nxt;
      end
      S_SUB: begin
        s_r   <= s_sub;
        sat_r <= sat_r || sub_ovf;
      end
      S_UNIT: begin
        am_r  <= unit_mag(latest_r);
        bm_r  <= unit_mag(prev_r);
        neg_r <= cfg.coefficient[COEF_W-1] ^ latest_r[SW-1] ^ prev_r[SW-1];
        d_r   <= D_W'(count_r) * D_W'(energy_r);
      end
      S_SQ: begin
        sqa_r <= PAB_W'(am_r) * PAB_W'(am_r);
        sqb_r <= PAB_W'(bm_r) * PAB_W'(bm_r);
        pab_r <= PAB_W'(am_r) * PAB_W'(bm_r);
      end
      S_CX: begin
        t_r   <= T_W'(s_sq) << FRAC_BITS;
        xlo_r <= XP_W'(c_abs) * XP_W'(pab_r[UNIT_W-1:0]);
        xhi_r <= XP_W'(c_abs) * XP_W'(pab_r[PAB_W-1:UNIT_W]);
      end
      S_SUM: begin
        xsum_r <= (T_W'(xhi_r) << UNIT_W) + T_W'(xlo_r);
      end
      S_ACC: begin
        acc_r <= acc_nxt;
      end
      S_RNDM: begin
        msat_r <= rq[63];
        mag_r  <= rq[63] ? '1 : rq[MAG_W-1:0];
      end
      S_CHK: begin
        // The top quotient bits are known to be zero since mag < 2*D.
        rem_r   <= n_init[REM_W+Q_W-1:Q_W];
        nbits_r <= n_init[Q_W-1:0];
        q_r     <= '0;
      end
      S_DIV: begin
        rem_r   <= ge ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
        nbits_r <= {nbits_r[Q_W-2:0], 1'b0};
        q_r     <= q_fin;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign result    = res_r;

endmodule

// ===== rtl/goertzel_tone_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Goertzel tone detector
// Single-bin Goertzel detector with energy, sample count and purity output.
// ----------------------------------------------------------------------------
// Each request gives exactly one result. For an add-sample request the latest
// state goes through one multiply, one rounding step and two saturating adds,
// each registered, before the next sample can use it. A rejected sample, a
// clear or an unused command is answered from the idle state. A detect steps
// through the unit, square, cross-term, sum, accumulate, rounding and check
// states, then the one-bit-per-cycle restoring divider for the purity, which
// is skipped when the block is empty or the purity saturates. A two-entry
// queue sits between the input and the back end. A result register on the
// output holds each result until it is taken, and the back end takes the next
// request only when that register is empty or is read in the same cycle.
module goertzel_tone_detector
  import gtd_pkg::*;
#(
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int STATE_BITS  = STATE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [SMP_PORT_W-1:0] in_sample,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [1:0]            out_status,
  output logic [CNT_W-1:0]      out_sample_count,
  output logic [MAG_W-1:0]      out_magnitude_squared,
  output logic [ENERGY_W-1:0]   out_energy,
  output logic [PUR_W-1:0]      out_purity,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SMP_W   = (SAMPLE_BITS < SMP_PORT_W) ? SAMPLE_BITS : SMP_PORT_W;
  localparam int ENTRY_W = OP_W + SMP_W + 1;

  logic               q_push, q_pop, q_full, q_empty;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;
  gtd_cfg_t           cfg;
  gtd_result_t        result;

  gtd_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .in_sample  (in_sample),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_wdata    (q_wdata),
    .cfg        (cfg)
  );

  gtd_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  gtd_back #(
    .MAX_BLOCK  (MAX_BLOCK),
    .SAMPLE_BITS(SAMPLE_BITS),
    .STATE_BITS (STATE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .result    (result)
  );

  assign out_status            = result.status;
  assign out_sample_count      = result.sample_count;
  assign out_magnitude_squared = result.magnitude_squared;
  assign out_energy            = result.energy;
  assign out_purity            = result.purity;

  // The back end only takes a request that the queue actually holds.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("request taken from an empty queue");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !q_pop))
    else $error("activity right after reset");

  a_empty_no_purity: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_EMPTY) |-> (out_purity == '0))
    else $error("empty block reported a purity");

endmodule
